// ===== rtl/wolp_pkg.sv =====
// shared types, widths and codes of the write-once linear probe hash table
package wolp_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int KEY_W          = 64;
    localparam int VAL_W          = 64;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 11;
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 3;

    localparam logic [COUNT_W-1:0] FILL_LIMIT_RST = COUNT_W'(512);

    // register index, taken from the word address bit of paddr
    localparam logic REG_FILL_LIMIT = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_RETRIEVE = 2'd1,
        FUNC_CLEAR    = 2'd2,
        FUNC_NOP      = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_KEY_ZERO  = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

endpackage

// ===== rtl/wolp_if.sv =====
// request and response channel interfaces of the hash table
interface wolp_in_if;
    import wolp_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  lookup_key;
    logic [VAL_W-1:0]  value_in;

    modport source (output valid, output func, output lookup_key, output value_in,
                    input ready);
    modport sink   (input valid, input func, input lookup_key, input value_in,
                    output ready);
endinterface

interface wolp_out_if;
    import wolp_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [VAL_W-1:0]    value_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output ok, output value_out, output status,
                    input ready);
    modport sink   (input valid, input ok, input value_out, input status,
                    output ready);
endinterface

// ===== rtl/wolp_ram.sv =====
// single-port synchronous ram with registered read
module wolp_ram #(
    parameter int WIDTH = wolp_pkg::KEY_W,
    parameter int DEPTH = wolp_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/write_once_linear_probe_hash.sv =====
// write-once hash table, open addressing with linear probing, memory based
//
//  channel   dir  handshake          word
//  i_req     in   valid / ready      func, lookup_key, value_in
//  o_rsp     out  valid / ready      ok, value_out, status
//  apb       in   psel/penable/...   fill_limit at byte address 0
//
// insert and retrieve do one read and one compare of the key ram for each slot
// visited. key zero and unused codes go straight to the reply step.
// clear wipes the key ram one slot a cycle, then replies.
// after reset the same wipe runs before i_req is ready.
// a finished word waits in the output register; a new word is taken meanwhile,
// and only the reply step stalls when the output register is still full.
module write_once_linear_probe_hash #(
    parameter int TABLE_SIZE = wolp_pkg::TABLE_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wolp_in_if.sink                             i_req,
    wolp_out_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wolp_pkg::PADDR_W-1:0]        paddr,
    input  logic [wolp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wolp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import wolp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_WIPE_RST,
        S_WIPE,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_REPLY
    } t_state;

    t_state               r_state, n_state;
    t_func                r_func, n_func;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VAL_W-1:0]     r_val, n_val;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [IDX_W-1:0]     r_probe, n_probe;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [COUNT_W-1:0]   r_fill_limit, n_fill_limit;
    logic                 r_res_ok, n_res_ok;
    logic [VAL_W-1:0]     r_res_value, n_res_value;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_ok, n_out_ok;
    logic [VAL_W-1:0]     r_out_value, n_out_value;
    t_status              r_out_status, n_out_status;

    logic                 key_we;
    logic [KEY_W-1:0]     key_wdata;
    logic [KEY_W-1:0]     key_rdata;
    logic                 val_we;
    logic [VAL_W-1:0]     val_rdata;
    logic                 in_ready;
    logic                 cfg_write;
    logic                 slot_hit;
    logic                 slot_empty;

    wolp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_addr  (r_slot),
        .i_wdata (key_wdata),
        .o_rdata (key_rdata)
    );

    wolp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_addr  (r_slot),
        .i_wdata (r_val),
        .o_rdata (val_rdata)
    );

    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_FILL_LIMIT) ? APB_DATA_W'(r_fill_limit) : '0;

    assign slot_hit   = (key_rdata == r_key);
    assign slot_empty = (key_rdata == '0);

    assign i_req.ready     = in_ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ok        = r_out_ok;
    assign o_rsp.value_out = r_out_value;
    assign o_rsp.status    = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_key        = r_key;
        n_val        = r_val;
        n_slot       = r_slot;
        n_probe      = r_probe;
        n_count      = r_count;
        n_fill_limit = r_fill_limit;
        n_res_ok     = r_res_ok;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_ok     = r_out_ok;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        key_we       = 1'b0;
        key_wdata    = r_key;
        val_we       = 1'b0;
        in_ready     = 1'b0;

        if (cfg_write && (paddr[2] == REG_FILL_LIMIT)) begin
            n_fill_limit = pwdata[COUNT_W-1:0];
        end

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_WIPE_RST, S_WIPE: begin
                key_we    = 1'b1;
                key_wdata = '0;
                n_slot    = r_slot + 1'b1;
                if (r_slot == SLOT_LAST) begin
                    n_count = '0;
                    n_state = (r_state == S_WIPE_RST) ? S_IDLE : S_REPLY;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    n_func       = t_func'(i_req.func);
                    n_key        = i_req.lookup_key;
                    n_val        = i_req.value_in;
                    n_slot       = i_req.lookup_key[IDX_W-1:0];
                    n_probe      = '0;
                    n_res_ok     = 1'b0;
                    n_res_value  = '0;
                    n_res_status = STAT_DONE;
                    case (t_func'(i_req.func))
                        FUNC_INSERT, FUNC_RETRIEVE: begin
                            if (i_req.lookup_key == '0) begin
                                n_res_status = STAT_KEY_ZERO;
                                n_state      = S_REPLY;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_slot  = '0;
                            n_state = S_WIPE;
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_READ: begin
                // key and value of r_slot come out of the rams next cycle
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (slot_hit) begin
                    if (r_func == FUNC_INSERT) begin
                        n_res_status = STAT_DUPLICATE;
                    end else begin
                        n_res_ok    = 1'b1;
                        n_res_value = val_rdata;
                    end
                    n_state = S_REPLY;
                end else if (slot_empty) begin
                    if (r_func == FUNC_INSERT) begin
                        if (r_count >= r_fill_limit) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            key_we   = 1'b1;
                            val_we   = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_res_ok = 1'b1;
                        end
                    end else begin
                        n_res_status = STAT_NOT_FOUND;
                    end
                    n_state = S_REPLY;
                end else if (r_probe == SLOT_LAST) begin
                    // whole table probed without a match or a free slot
                    n_res_status = (r_func == FUNC_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                    n_state      = S_REPLY;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_probe = r_probe + 1'b1;
                    n_state = S_READ;
                end
            end
            S_REPLY: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_ok     = r_res_ok;
                    n_out_value  = r_res_value;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WIPE_RST;
            r_slot       <= '0;
            r_count      <= '0;
            r_fill_limit <= FILL_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_count      <= n_count;
            r_fill_limit <= n_fill_limit;
            r_out_valid  <= n_out_valid;
        end
        r_func       <= n_func;
        r_key        <= n_key;
        r_val        <= n_val;
        r_probe      <= n_probe;
        r_res_ok     <= n_res_ok;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_ok     <= n_out_ok;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end
endmodule

// ===== rtl/wolp_checker.sv =====
// port-level assertions for the hash table, bound to the top level
module wolp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic                                i_out_ok,
    input logic [wolp_pkg::VAL_W-1:0]          i_out_value,
    input logic [wolp_pkg::STATUS_W-1:0]       i_out_status,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [wolp_pkg::PADDR_W-1:0]        paddr,
    input logic [wolp_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [wolp_pkg::APB_DATA_W-1:0]     prdata
);
    import wolp_pkg::*;

    // a successful word always carries the done code
    a_ok_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ok |-> i_out_status == STAT_DONE)
        else $error("ok word with a failure status");

    // a nonzero value only comes from a retrieve hit
    a_value_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_value != '0) |-> i_out_ok)
        else $error("nonzero value_out without ok");

    // the table wipe after reset holds off new words
    a_wipe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during the reset wipe");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled response word changed");

    // fill_limit reads back the low COUNT_W bits of what was written
    a_fill_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == REG_FILL_LIMIT)
        |=> (paddr[2] != REG_FILL_LIMIT) ||
            (prdata == APB_DATA_W'($past(pwdata[COUNT_W-1:0]))))
        else $error("fill_limit readback mismatch");
endmodule

bind write_once_linear_probe_hash wolp_checker u_wolp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_ok     (o_rsp.ok),
    .i_out_value  (o_rsp.value_out),
    .i_out_status (o_rsp.status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);
